// ===== sv/frtp_pkg.sv =====
// Package: payload types and constants for the float rounding block.
`timescale 1ns / 1ps
`default_nettype none
package frtp_pkg;
	localparam logic [1:0] REQ_ABSTRACT = 2'd0;
	localparam logic [1:0] REQ_F32      = 2'd1;
	localparam logic [1:0] REQ_F16      = 2'd2;
	localparam logic [63:0] H_FAIL_BITS = 64'h40EF_FE00_0000_0000;
	localparam logic [63:0] H_MAX_BITS  = 64'h40EF_FC00_0000_0000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] value_bits;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_bits;
		logic        ok;
	} out_item_t;
endpackage
`default_nettype wire

// ===== sv/frtp_round.sv =====
// Combinational binary64 rounding to binary32/binary16 grid, or pass-through.
`timescale 1ns / 1ps
`default_nettype none
module frtp_round
	import frtp_pkg::*;
(
	input  wire in_item_t  item,
	output out_item_t      res
);
	logic        sgn;
	logic [10:0] be;
	logic [52:0] m;
	logic        f32;
	logic [12:0] ue, emin, te, qe, top, sh;
	logic [53:0] mq, q;
	logic [52:0] rem, half;
	logic        rnd;
	logic [5:0]  lead;
	logic [63:0] rb;
	logic        fail;

	always_comb begin
		sgn  = item.value_bits[63];
		be   = item.value_bits[62:52];
		m    = {1'b1, item.value_bits[51:0]};
		f32  = (item.req_type == REQ_F32);
		ue   = {2'b00, be} - 13'd1023;
		emin = f32 ? -13'sd126 : -13'sd14;
		te   = ($signed(ue) < $signed(emin)) ? emin : ue;
		qe   = te - (f32 ? 13'd23 : 13'd10);
		// shift is 52 + qe - ue, always positive here
		sh   = 13'd52 + qe - ue;
		mq   = '0; rem = '0; half = '0; q = '0; rnd = 1'b0;
		lead = '0; top = '0; rb = {sgn, 63'd0}; fail = 1'b0;
		if (be != 11'd0 && $signed(sh) < 13'sd54) begin
			mq   = {1'b0, m} >> sh[5:0];
			rem  = m & ((53'd1 << sh[5:0]) - 53'd1);
			half = 53'd1 << (sh[5:0] - 6'd1);
			rnd  = (rem > half) || (rem == half && mq[0]);
			q    = mq + {53'd0, rnd};
			if (q != '0) begin
				// leading one of q (below 2^26)
				for (int i = 0; i < 26; i++)
					if (q[i]) lead = 6'(i);
				top = qe + {7'd0, lead};
				rb  = {sgn, 11'(top + 13'd1023), 52'(q << (6'd52 - lead))};
			end
		end
		unique case (item.req_type)
			REQ_F32: begin
				if ($signed(top) >= 13'sd128 && q != '0) fail = 1'b1;
			end
			REQ_F16: begin
				if ({1'b0, item.value_bits[62:0]} > H_FAIL_BITS) fail = 1'b1;
				else if ($signed(top) >= 13'sd16 && q != '0)
					rb = {sgn, H_MAX_BITS[62:0]};
			end
			default: rb = item.value_bits;
		endcase
		if (be == 11'h7FF) fail = 1'b1;
		res.ok          = !fail;
		res.result_bits = fail ? 64'd0 : rb;
	end
endmodule
`default_nettype wire

// ===== sv/float_round_to_target_precision.sv =====
// Each accepted input transaction is written to one result register; one per cycle unless out_ready stalls.
// Rounding is a single combinational pass feeding a registered output slot,
// so a new transaction is accepted each cycle whenever the slot drains or is
// empty. Reset (arst_n low, asynchronous) empties the slot.
`timescale 1ns / 1ps
`default_nettype none
module float_round_to_target_precision
	import frtp_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire            out_ready,
	output out_item_t      out_data
);
	out_item_t res;
	logic      valid_q;

	frtp_round u_round (.item(in_data), .res(res));

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (in_ready) valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) out_data <= res;
	end
endmodule
`default_nettype wire

// ===== sv/frtp_checker.sv =====
// Port checker for the rounding block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module frtp_checker
	import frtp_pkg::*;
(
	input wire            clk,
	input wire            arst_n,
	input wire            in_valid,
	input wire            in_ready,
	input wire in_item_t  in_data,
	input wire            out_valid,
	input wire            out_ready,
	input wire out_item_t out_data
);
	// a result held back keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// accepted input gives a result next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("result missing");
	// a failed result carries zero bits
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.result_bits == 64'd0)
		else $error("failed result not zero");
	// input is never refused while the slot is empty
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("ready low with empty slot");
endmodule

bind float_round_to_target_precision frtp_checker u_chk (.*);
`default_nettype wire

// ===== dv/float_round_to_target_precision_tb.sv =====
// Testbench for the float rounding block: directed table plus random values.
`timescale 1ns / 1ps
`default_nettype none
module float_round_to_target_precision_tb;
	import frtp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_RANDOM = 1330;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MANT_MASK = 64'h000F_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	out_item_t rounded_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit sending = 1'b0;

	typedef struct {
		logic [1:0] req;
		logic [63:0] val;
		bit known;
		logic [63:0] res;
		logic ok;
	} vector_t;

	float_round_to_target_precision u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Round a binary64 value onto a grid of prec bits with minimum exponent emin
	function automatic void grid_round(input logic [63:0] bits, input int prec,
			input int emin, output logic [63:0] res, output int top);
		logic [63:0] sgn, m, q, rem, half, mant;
		int be, ue, te, qe, s, lead;
		sgn = bits & SIGN_MASK;
		be = int'(bits[62:52]);
		top = -2000;
		res = sgn;
		if (be == 0)
			return;
		ue = be - 1023;
		m = (bits & MANT_MASK) | (64'd1 << 52);
		te = (ue < emin) ? emin : ue;
		qe = te - (prec - 1);
		s = 52 + qe - ue;
		if (s >= 54)
			return;
		q = m >> s;
		rem = m & ((64'd1 << s) - 64'd1);
		half = 64'd1 << (s - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 64'd1;
		if (q == 0)
			return;
		lead = 0;
		while (lead < 62 && (q >> (lead + 1)) != 0)
			lead++;
		mant = (q << (52 - lead)) & MANT_MASK;
		top = lead + qe;
		res = sgn | (64'(lead + qe + 1023) << 52) | mant;
	endfunction

	function automatic out_item_t predict_rounding(input in_item_t it);
		out_item_t r;
		logic [63:0] res;
		int top;
		r.ok = 1'b1;
		r.result_bits = it.value_bits;
		if (it.value_bits[62:52] == 11'h7FF) begin
			r.ok = 1'b0;
		end else if (it.req_type == REQ_F32) begin
			grid_round(it.value_bits, 24, -126, res, top);
			if (top >= 128)
				r.ok = 1'b0;
			r.result_bits = res;
		end else if (it.req_type == REQ_F16) begin
			if ((it.value_bits & ~SIGN_MASK) > H_FAIL_BITS) begin
				r.ok = 1'b0;
			end else begin
				grid_round(it.value_bits, 11, -14, res, top);
				r.result_bits = (top >= 16) ? ((it.value_bits & SIGN_MASK) | H_MAX_BITS)
					: res;
			end
		end
		if (!r.ok)
			r.result_bits = '0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Result checking and receiver stalls
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (rounded_q.size() == 0) begin
					report_mismatch("unexpected transaction", out_data.result_bits, '0);
				end else begin
					want = rounded_q.pop_front();
					if (out_data.result_bits !== want.result_bits)
						report_mismatch("result_bits", out_data.result_bits,
							want.result_bits);
					if (out_data.ok !== want.ok)
						report_mismatch("ok", 64'(out_data.ok), 64'(want.ok));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !sending)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Drive one transaction and hold it until accepted; valid stays high
	// afterwards so back-to-back transactions need no gap
	task automatic send_value(input logic [1:0] req, input logic [63:0] val,
			input bit known, input out_item_t given);
		in_item_t it;
		it.req_type = req;
		it.value_bits = val;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		rounded_q.push_back(known ? given : predict_rounding(it));
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		logic [10:0] e;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: e = 11'(1023 + $urandom_range(16) - 2);
			1: e = 11'(1023 - 14 - $urandom_range(12));
			2: e = 11'(1023 + 120 + $urandom_range(10));
			3: e = 11'(1023 - 126 - $urandom_range(26));
			4: e = ($urandom_range(3) == 0) ? 11'h7FF : 11'd0;
			default: e = v[62:52];
		endcase
		v[62:52] = e;
		// Push some mantissas onto rounding ties
		if ($urandom_range(3) == 0)
			v[28:0] = {1'b1, 28'd0} >> $urandom_range(0, 1) * 13;
		return v;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (rounded_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		vector_t table_v[$];
		out_item_t given;
		int phase;
		table_v = '{
			'{REQ_ABSTRACT, 64'h3FF0_0000_0000_0001, 1, 64'h3FF0_0000_0000_0001, 1},
			'{REQ_UNUSED, 64'hC000_0000_0000_0000, 1, 64'hC000_0000_0000_0000, 1},
			'{REQ_ABSTRACT, 64'h7FF0_0000_0000_0000, 1, 64'h0, 0},
			'{REQ_F32, 64'hFFF8_0000_0000_0000, 1, 64'h0, 0},
			'{REQ_F16, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'h0, 0},
			'{REQ_F32, 64'h8000_0000_0000_0000, 1, 64'h8000_0000_0000_0000, 1},
			'{REQ_F16, 64'h8000_0000_0000_0000, 1, 64'h8000_0000_0000_0000, 1},
			'{REQ_F16, 64'h8000_0000_0000_0001, 1, 64'h8000_0000_0000_0000, 1},
			'{REQ_F32, 64'h000F_FFFF_FFFF_FFFF, 1, 64'h0, 1},
			'{REQ_F16, 64'h40EF_FE00_0000_0001, 1, 64'h0, 0},
			'{REQ_F16, H_FAIL_BITS, 1, H_MAX_BITS, 1},
			'{REQ_F16, 64'hC0EF_FD00_0000_0000, 1, SIGN_MASK | H_MAX_BITS, 1},
			'{REQ_F16, H_MAX_BITS, 1, H_MAX_BITS, 1},
			'{REQ_F32, 64'h47EF_FFFF_FFFF_FFFF, 1, 64'h0, 0},
			'{REQ_F32, 64'h47EF_FFFF_E000_0000, 1, 64'h47EF_FFFF_E000_0000, 1},
			'{REQ_F32, 64'h3FF0_0000_1000_0000, 0, 64'h0, 0},
			'{REQ_F32, 64'h3FF0_0000_3000_0000, 0, 64'h0, 0},
			'{REQ_F32, 64'h36A0_0000_0000_0000, 0, 64'h0, 0},
			'{REQ_F32, 64'h3690_0000_0000_0001, 0, 64'h0, 0},
			'{REQ_F16, 64'h3E70_0000_0000_0000, 0, 64'h0, 0},
			'{REQ_F16, 64'h3E60_0000_0000_0000, 0, 64'h0, 0},
			'{REQ_F16, 64'h3F10_1000_0000_0000, 0, 64'h0, 0},
			'{REQ_F16, 64'hBFF0_0300_0000_0000, 0, 64'h0, 0},
			'{REQ_F16, 64'h3F0F_FFFF_FFFF_FFFF, 0, 64'h0, 0}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sending = 1'b1;

		// Directed table
		foreach (table_v[i]) begin
			given.result_bits = table_v[i].res;
			given.ok = table_v[i].ok;
			send_value(table_v[i].req, table_v[i].val, table_v[i].known, given);
		end
		// Hold off until every outstanding result has come back
		drain();

		// Random values over the idling phases
		for (int n = 0; n < N_RANDOM; n++) begin
			phase = n / (N_RANDOM / 4);
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 45; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 45; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			send_value(2'($urandom_range(3)), random_value(), 0, given);
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== float_round_to_target_precision.f =====
sv/frtp_pkg.sv
sv/frtp_round.sv
sv/float_round_to_target_precision.sv
sv/frtp_checker.sv
dv/float_round_to_target_precision_tb.sv
